// File: sv/tli_pkg.sv
package tli_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	// field widths fixed by the interface
	localparam int CFG_W = 11;
	localparam int IDX_W = 10;
	localparam int DW = 32;

	// serial divider, two quotient bits per cycle
	localparam int DIV_BITS = 2;
	localparam int DIV_STEPS = DW / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] entry_index;
		logic [DW-1:0] energy;
		logic [DW-1:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic [DW-1:0] value_out;
		logic no_data;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_DROP,
		OP_QUERY,
		OP_EMPTY
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [AW-1:0] index;
		logic [DW-1:0] energy;
		logic [DW-1:0] value;
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_INTERP,
		S_MUL,
		S_DIV,
		S_FIX,
		S_OUT
	} state_t;

endpackage

// File: sv/tli_ram.sv
module tli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/tli_front.sv
module tli_front (
	input tli_pkg::in_item_t in_data,
	input logic [tli_pkg::CFG_W-1:0] points_in_use,
	output tli_pkg::op_t op
);
	import tli_pkg::*;

	logic in_range;

	assign in_range = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);

	// classify the incoming transaction
	always_comb begin
		op.index = AW'(in_data.entry_index);
		op.energy = in_data.energy;
		op.value = in_data.value_in;
		if (in_data.action == ACT_LOAD) begin
			op.kind = in_range ? OP_LOAD : OP_DROP;
		end else begin
			op.kind = (points_in_use == '0) ? OP_EMPTY : OP_QUERY;
		end
	end

endmodule

// File: sv/tli_queue.sv
module tli_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tli_pkg::op_t push_op,
	output logic full,
	input logic pop,
	output logic valid,
	output tli_pkg::op_t head
);
	import tli_pkg::*;

	op_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	assign full = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head = slot_q[rd_ptr_q];

endmodule

// File: sv/tli_back.sv
module tli_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input tli_pkg::op_t q_op,
	output logic q_pop,
	input logic [tli_pkg::CFG_W-1:0] points_in_use,
	output logic out_valid,
	input logic out_stall,
	output tli_pkg::out_item_t out_data
);
	import tli_pkg::*;

	state_t st_q, st_d;

	logic [CW-1:0] n_eff;
	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic [CW:0] mid_sum;
	logic [CW-1:0] span;
	logic [DW-1:0] e_q, x0_q, y0_q, x1_q, y1_q;
	logic [DW-1:0] dx_q, de_q, dy_q;
	logic up_q;
	logic [DW-1:0] rem_q, quo_q, rem_d, quo_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DW-1:0] res_q;
	logic nd_q;
	logic out_valid_q;
	out_item_t out_q;
	logic out_free;

	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [2*DW-1:0] ram_rdata;
	logic [DW-1:0] rd_x, rd_y;

	// effective point count, clamped to the table depth
	assign n_eff = (32'(points_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
		: CW'(points_in_use);
	assign span = hi_q - lo_q;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign rd_x = ram_rdata[2*DW-1:DW];
	assign rd_y = ram_rdata[DW-1:0];
	assign out_free = !out_valid_q || !out_stall;

	// energy and value stored side by side
	tli_ram #(
		.WIDTH(2 * DW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(q_op.index),
		.wdata({q_op.energy, q_op.value}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// restoring division, two quotient bits per cycle
	always_comb begin
		logic [DW:0] t;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {rem_d, quo_d[DW-1]};
			quo_d = {quo_d[DW-2:0], 1'b0};
			if (t >= {1'b0, dx_q}) begin
				t = t - {1'b0, dx_q};
				quo_d[0] = 1'b1;
			end
			rem_d = t[DW-1:0];
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_op.kind)
						OP_QUERY: st_d = S_FIRST;
						OP_EMPTY: st_d = S_OUT;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_FIRST: st_d = (e_q <= rd_x) ? S_OUT : S_LAST;
			S_LAST: st_d = (e_q >= rd_x) ? S_OUT : S_SRCH_RD;
			S_SRCH_RD: begin
				if (span > CW'(1)) begin
					st_d = S_SRCH_CMP;
				end else if (hi_q >= n_eff) begin
					st_d = S_OUT;
				end else begin
					st_d = S_INTERP;
				end
			end
			S_SRCH_CMP: st_d = S_SRCH_RD;
			S_INTERP: begin
				if (x1_q <= x0_q || e_q <= x0_q || e_q >= x1_q) begin
					st_d = S_OUT;
				end else begin
					st_d = S_MUL;
				end
			end
			S_MUL: st_d = S_DIV;
			S_DIV: st_d = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) ? S_FIX : S_DIV;
			S_FIX: st_d = S_OUT;
			S_OUT: st_d = out_free ? S_IDLE : S_OUT;
			default: st_d = S_IDLE;
		endcase
	end

	// queue pop and memory ports
	always_comb begin
		q_pop = 1'b0;
		ram_we = 1'b0;
		ram_raddr = '0;
		case (st_q)
			S_IDLE: begin
				q_pop = q_valid;
				ram_we = q_valid && (q_op.kind == OP_LOAD);
			end
			S_FIRST: ram_raddr = AW'(n_eff - CW'(1));
			S_SRCH_RD: ram_raddr = AW'(mid_sum[CW:1]);
			default: ram_raddr = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search and interpolation datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				e_q <= q_op.energy;
				res_q <= '0;
				nd_q <= q_op.kind == OP_EMPTY;
			end
			S_FIRST: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
				res_q <= rd_y;
			end
			S_LAST: begin
				res_q <= rd_y;
				lo_q <= '0;
				hi_q <= n_eff;
			end
			S_SRCH_RD: begin
				mid_q <= mid_sum[CW:1];
				res_q <= y0_q;
			end
			S_SRCH_CMP: begin
				if (rd_x >= e_q) begin
					hi_q <= mid_q;
					x1_q <= rd_x;
					y1_q <= rd_y;
				end else begin
					lo_q <= mid_q;
					x0_q <= rd_x;
					y0_q <= rd_y;
				end
			end
			S_INTERP: begin
				res_q <= (x1_q <= x0_q || e_q <= x0_q) ? y0_q : y1_q;
				dx_q <= x1_q - x0_q;
				de_q <= e_q - x0_q;
				up_q <= y1_q >= y0_q;
				dy_q <= (y1_q >= y0_q) ? y1_q - y0_q : y0_q - y1_q;
			end
			S_MUL: begin
				{rem_q, quo_q} <= dy_q * de_q;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			S_FIX: res_q <= up_q ? y0_q + quo_q : y0_q - quo_q;
			S_OUT: begin
				if (out_free) begin
					out_q.value_out <= res_q;
					out_q.no_data <= nd_q;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: sv/table_interpolation_lookup_core.sv
// piecewise linear lookup over a table of energy points and cross sections
//
// input channel (in_valid / in_stall / in_data): a load transaction
// (action 0) writes one energy and value at entry_index; a query
// transaction (action 1) returns one result on the output channel
// (out_valid / out_stall / out_data). loads return nothing.
// cfg_we / cfg_wdata set the number of points in use; write it only while
// the block is idle.
//
// a two-entry queue sits between input classification and the search
// engine. a load is written to the table as it is popped. a query goes
// through the pop, the first- and last-point checks, a binary search
// with a read step and a compare step per halving on the single table
// read port, an interpolation check, a multiply, the two-bit-per-cycle
// divider, a fix-up step and the output step; the engine finishes one
// query before it pops the next. an empty table goes from the pop to the
// output step, an energy clamped to the first point from the first-point
// check, and one clamped to the last point from the last-point check.
// a result sits in the output register while out_stall is high; the
// engine holds the next result until that register frees up, and the
// queue fills and raises in_stall.
// reset clears the point count, the queue and the output valid flag; table
// contents are undefined until written.
module table_interpolation_lookup_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tli_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output tli_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [tli_pkg::CFG_W-1:0] cfg_wdata
);
	import tli_pkg::*;

	logic [CFG_W-1:0] points_q;
	op_t front_op, head_op;
	logic q_full, q_valid, q_pop, q_push;

	// point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (cfg_we) begin
			points_q <= cfg_wdata;
		end
	end

	assign q_push = in_valid && !q_full;
	assign in_stall = q_full;

	tli_front u_front (
		.in_data(in_data),
		.points_in_use(points_q),
		.op(front_op)
	);

	tli_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_op(front_op),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(head_op)
	);

	tli_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_op(head_op),
		.q_pop(q_pop),
		.points_in_use(points_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// engine pops only a queued transaction
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// empty-table result carries a zero value
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_data |-> out_data.value_out == '0)
		else $error("no_data result with nonzero value");

	// a full queue keeps in_stall high until the engine pops
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> in_stall)
		else $error("queue lost an entry");

endmodule
